>>> rtl/core/lab2xyz_pkg.sv
// Shared types and fixed-point constants for the L*a*b* to XYZ converter.
package lab2xyz_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_WHITE_X = 2'd0,
		REG_WHITE_Y = 2'd1,
		REG_WHITE_Z = 2'd2
	} cfg_reg_t;

	localparam int CFG_IDX_W = 2;
	localparam int WHITE_W   = 15;
	localparam int WHITE_BITS = 14;
	localparam logic [WHITE_W-1:0] WHITE_X_D65 = 15'd15573;
	localparam logic [WHITE_W-1:0] WHITE_Y_D65 = 15'd16384;
	localparam logic [WHITE_W-1:0] WHITE_Z_D65 = 15'd17839;

	localparam int L_W    = 15;
	localparam int AB_W   = 16;
	localparam int OUT_W  = 20;

	// numerator 250*(L+16) + k*ab, sized for the widest input scaling
	localparam int NUM_W  = 26;
	localparam int MAG_W  = 25;

	// floor(n/3625) = (n*RECIP_3625) >> RECIP_SH, exact for n < 2^MAG_W
	localparam int RECIP_W  = 26;
	localparam int RECIP_SH = 37;
	localparam logic [RECIP_W-1:0] RECIP_3625 = 26'd37914195;
	localparam logic [11:0] DIV_3625 = 12'd3625;
	localparam int DIVP_W = MAG_W + RECIP_W;
	localparam int Q_W    = DIVP_W - RECIP_SH;
	localparam int RMD_W  = 12;
	localparam int HALF_DIV8 = 1812;

	// f values in Q.20
	localparam int F_BITS = 20;
	localparam int F_W    = 26;
	localparam int FMAG_W = 25;
	localparam int SQ_W   = 2 * FMAG_W;
	localparam int F2_W   = 30;
	localparam int CUBE_W = F2_W + FMAG_W;
	localparam int F3_W   = 35;
	localparam int T_W    = F3_W + 1;
	localparam int FD_W   = F_W + 1;
	localparam int LIN_W  = 45;
	localparam int LINR_W = 26;
	localparam int PROD_W = T_W + WHITE_W + 1;

	localparam logic [F3_W-1:0]        CUBE_LIMIT = 35'd9286;
	localparam logic signed [18:0]     FOUR_29THS = 19'sd144631;
	localparam logic signed [18:0]     INV_7787   = 19'sd134657;

endpackage

>>> rtl/core/cielab_to_xyz_converter.sv
// The s1 input register and channel stages s2 to s12 lie between an accepted input and m_tvalid.
// Throughput: one pixel per clock while the output is not held; numerator,
// two /3625 multiplier steps, square, cube and white scaling each hold their own stage.
// A held output (m_tvalid high, m_tready low) freezes the whole pipeline.
// Reset clears all valid bits and loads the D65 white point registers.
module cielab_to_xyz_converter import lab2xyz_pkg::*; #(
	parameter int IN_FRAC_BITS  = 8,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [47:0]          s_tdata,   // lightness[14:0], green_red[30:15], blue_yellow[46:31]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,   // tristim_x[19:0], tristim_y[39:20], tristim_z[59:40]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [WHITE_W-1:0]   cfg_wdata
);

	localparam int PIPE_STAGES = 12;
	localparam int LSUM_W = 18;
	localparam logic [LSUM_W-1:0] L_OFFSET = LSUM_W'(32'(16) << IN_FRAC_BITS);

	logic [WHITE_W-1:0] white_x_q, white_y_q, white_z_q;
	logic [PIPE_STAGES-1:0] vld_q;
	logic adv;

	logic [L_W-1:0]           lightness;
	logic signed [AB_W-1:0]   green_red, blue_yellow;
	logic [LSUM_W-1:0]        lsum_c;
	logic signed [NUM_W-1:0]  base_c, num_x_c, num_z_c;
	logic signed [NUM_W-1:0]  num_x_s1, num_y_s1, num_z_s1;
	logic signed [OUT_W-1:0]  tristim_x, tristim_y, tristim_z;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[PIPE_STAGES-1];

	assign lightness   = s_tdata[14:0];
	assign green_red   = s_tdata[30:15];
	assign blue_yellow = s_tdata[46:31];

	always_comb begin
		lsum_c  = LSUM_W'(lightness) + L_OFFSET;
		base_c  = NUM_W'(lsum_c) * NUM_W'(250);
		num_x_c = base_c + NUM_W'(green_red) * NUM_W'(58);
		num_z_c = base_c - NUM_W'(blue_yellow) * NUM_W'(145);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_x_q <= WHITE_X_D65;
			white_y_q <= WHITE_Y_D65;
			white_z_q <= WHITE_Z_D65;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_WHITE_X: white_x_q <= cfg_wdata;
				REG_WHITE_Y: white_y_q <= cfg_wdata;
				REG_WHITE_Z: white_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_STAGES-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s1 <= num_x_c;
			num_y_s1 <= base_c;
			num_z_s1 <= num_z_c;
		end
	end

	lab2xyz_chan #(
		.IN_FRAC_BITS  (IN_FRAC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_chan_x (
		.clk    (clk),
		.adv    (adv),
		.num_s1 (num_x_s1),
		.white  (white_x_q),
		.result (tristim_x)
	);

	lab2xyz_chan #(
		.IN_FRAC_BITS  (IN_FRAC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_chan_y (
		.clk    (clk),
		.adv    (adv),
		.num_s1 (num_y_s1),
		.white  (white_y_q),
		.result (tristim_y)
	);

	lab2xyz_chan #(
		.IN_FRAC_BITS  (IN_FRAC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_chan_z (
		.clk    (clk),
		.adv    (adv),
		.num_s1 (num_z_s1),
		.white  (white_z_q),
		.result (tristim_z)
	);

	assign m_tdata = {4'b0000, tristim_z, tristim_y, tristim_x};

endmodule

>>> rtl/core/lab2xyz_chan.sv
// One output channel: rounded divide, inverse companding and white scaling.
module lab2xyz_chan import lab2xyz_pkg::*; #(
	parameter int IN_FRAC_BITS  = 8,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [NUM_W-1:0] num_s1,
	input  logic [WHITE_W-1:0]      white,
	output logic signed [OUT_W-1:0] result
);

	// (num*2^(20-IFB) + 14500)/29000 split as /8 then two steps of /3625
	localparam int FINE_SH = 17 - IN_FRAC_BITS;
	localparam int OUT_SH  = F_BITS + WHITE_BITS - OUT_FRAC_BITS;
	localparam logic [SQ_W-1:0]   HALF_SQ   = SQ_W'(64'(1) << (F_BITS - 1));
	localparam logic [LIN_W-1:0]  HALF_LIN  = LIN_W'(64'(1) << (F_BITS - 1));
	localparam logic [CUBE_W-1:0] HALF_CUBE = CUBE_W'(64'(1) << (F_BITS - 1));
	localparam logic [PROD_W-1:0] HALF_OUT  = PROD_W'(64'(1) << (OUT_SH - 1));
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'(1) << (OUT_W - 1)) - 64'(1));
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	logic                     neg_s2, neg_s3, neg_s4, neg_s5;
	logic [MAG_W-1:0]         mag_s2, mag_s3;
	logic [DIVP_W-1:0]        prod0_s3, prod1_s5;
	logic [Q_W-1:0]           q0_s4, q0_s5;
	logic [MAG_W-1:0]         n1_s4;
	logic signed [F_W-1:0]    f_s6;
	logic [FMAG_W-1:0]        fmag_s6, fmag_s7, fmag_s8;
	logic                     fpos_s6, fpos_s7, fpos_s8, fpos_s9;
	logic [SQ_W-1:0]          sq_s7;
	logic signed [LIN_W-1:0]  lin_s7;
	logic [F2_W-1:0]          f2_s8;
	logic signed [LINR_W-1:0] linr_s8, linr_s9;
	logic [CUBE_W-1:0]        cube_s9;
	logic signed [T_W-1:0]    t_s10;
	logic signed [PROD_W-1:0] prod_s11;
	logic signed [OUT_W-1:0]  res_s12;

	logic [Q_W-1:0]           q0_c, q1_c;
	logic [RMD_W-1:0]         r0_c;
	logic [FMAG_W-1:0]        fmag_c;
	logic signed [FD_W-1:0]   fdiff_c;
	logic signed [LIN_W-1:0]  lin_adj_c;
	logic [F3_W-1:0]          f3_c;
	logic signed [T_W-1:0]    linr_ext_c;
	logic signed [PROD_W-1:0] out_adj_c, out_sh_c;
	logic signed [OUT_W-1:0]  out_sat_c;

	always_comb begin
		q0_c = prod0_s3[RECIP_SH +: Q_W];
		r0_c = RMD_W'(mag_s3 - MAG_W'(q0_c) * MAG_W'(DIV_3625));
		q1_c = prod1_s5[RECIP_SH +: Q_W];
		fmag_c = FMAG_W'((32'(q0_s5) << FINE_SH) + 32'(q1_c));
		fdiff_c = FD_W'(f_s6) - FD_W'(FOUR_29THS);
		// halves away from zero: add half, less one when negative
		lin_adj_c = lin_s7 + HALF_LIN - LIN_W'(lin_s7[LIN_W-1]);
		f3_c = F3_W'((cube_s9 + HALF_CUBE) >> F_BITS);
		linr_ext_c = T_W'(linr_s9);
		out_adj_c = prod_s11 + HALF_OUT - PROD_W'(prod_s11[PROD_W-1]);
		out_sh_c = out_adj_c >>> OUT_SH;
		if (out_sh_c > SAT_HI) begin
			out_sat_c = OUT_W'(SAT_HI);
		end else if (out_sh_c < SAT_LO) begin
			out_sat_c = OUT_W'(SAT_LO);
		end else begin
			out_sat_c = OUT_W'(out_sh_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2   <= num_s1[NUM_W-1];
			mag_s2   <= num_s1[NUM_W-1] ? MAG_W'(-num_s1) : MAG_W'(num_s1);

			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
			prod0_s3 <= DIVP_W'(mag_s2) * DIVP_W'(RECIP_3625);

			neg_s4   <= neg_s3;
			q0_s4    <= q0_c;
			n1_s4    <= MAG_W'((32'(r0_c) << FINE_SH) + 32'(HALF_DIV8));

			neg_s5   <= neg_s4;
			q0_s5    <= q0_s4;
			prod1_s5 <= DIVP_W'(n1_s4) * DIVP_W'(RECIP_3625);

			fmag_s6  <= fmag_c;
			f_s6     <= neg_s5 ? -F_W'(fmag_c) : F_W'(fmag_c);
			fpos_s6  <= !neg_s5 && (fmag_c != '0);

			fmag_s7  <= fmag_s6;
			fpos_s7  <= fpos_s6;
			sq_s7    <= SQ_W'(fmag_s6) * SQ_W'(fmag_s6);
			lin_s7   <= LIN_W'(fdiff_c) * LIN_W'(INV_7787);

			fmag_s8  <= fmag_s7;
			fpos_s8  <= fpos_s7;
			f2_s8    <= F2_W'((sq_s7 + HALF_SQ) >> F_BITS);
			linr_s8  <= LINR_W'(lin_adj_c >>> F_BITS);

			fpos_s9  <= fpos_s8;
			linr_s9  <= linr_s8;
			cube_s9  <= CUBE_W'(f2_s8) * CUBE_W'(fmag_s8);

			// cube branch only for positive f above the knee
			t_s10    <= (fpos_s9 && (f3_c > CUBE_LIMIT)) ? T_W'(f3_c) : linr_ext_c;

			prod_s11 <= PROD_W'(t_s10) * PROD_W'($signed({1'b0, white}));

			res_s12  <= out_sat_c;
		end
	end

	assign result = res_s12;

endmodule
